### hw/rtl/credential_entry_and_check_macros.svh
// Assertion helpers for the credential entry RTL.
`ifndef CREDENTIAL_ENTRY_AND_CHECK_MACROS_SVH
`define CREDENTIAL_ENTRY_AND_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CEC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/cec_pkg.sv
`default_nettype none

package cec_pkg;

  localparam int MAX_LEN_DEFAULT = 20;

  localparam logic [7:0] CHAR_ENTER_CR  = 8'h0D;
  localparam logic [7:0] CHAR_ENTER_SI  = 8'h0F;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] CFG_MAX_TRIES       = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MIN_LENGTH      = 2'd2;

  localparam logic [3:0] MAX_TRIES_RESET       = 4'd3;
  localparam logic [3:0] LOCKOUT_SECONDS_RESET = 4'd5;
  localparam logic [4:0] MIN_LENGTH_RESET      = 5'd6;

  typedef enum logic [2:0] {
    PH_ENROLL_USER = 3'd0,
    PH_ENROLL_PASS = 3'd1,
    PH_ENTER_USER  = 3'd2,
    PH_ENTER_PASS  = 3'd3,
    PH_LOCKOUT     = 3'd4,
    PH_SIGNED_IN   = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_CHAR_TAKEN   = 4'd1,
    EV_TOO_SHORT    = 4'd2,
    EV_USER_ENROLL  = 4'd3,
    EV_PASS_ENROLL  = 4'd4,
    EV_USER_ENTERED = 4'd5,
    EV_FAIL         = 4'd6,
    EV_SIGNED_IN    = 4'd7,
    EV_LOCK_START   = 4'd8,
    EV_LOCK_TICK    = 4'd9,
    EV_LOCK_OVER    = 4'd10
  } event_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [3:0] tries_left;
    logic [3:0] seconds_left;
    logic [4:0] entry_length;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic use_pass;
  } store_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/cec_store.sv
`default_nettype none

// Enrolled username and password bytes; one write port, one registered read port.
module cec_store #(
  parameter int MAX_LEN = cec_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                       clk,
  input  wire cec_pkg::store_ctl_t        ctl,
  input  wire logic [$clog2(MAX_LEN)-1:0] idx,
  input  wire logic [$clog2(MAX_LEN)-1:0] rd_idx,
  input  wire logic [7:0]                 byte_data,
  output logic                            match
);

  logic [7:0] user_mem [MAX_LEN];
  logic [7:0] pass_mem [MAX_LEN];
  logic [7:0] user_rd;
  logic [7:0] pass_rd;

  // Fetch the byte for the position the next item will land on.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.use_pass) begin
      user_mem[idx] <= byte_data;
    end
    if (ctl.wr_en && ctl.use_pass) begin
      pass_mem[idx] <= byte_data;
    end
    user_rd <= user_mem[rd_idx];
    pass_rd <= pass_mem[rd_idx];
  end

  // Compare the typed byte against the stored one at the same position.
  always_comb begin
    if (ctl.use_pass) begin
      match = (pass_rd == byte_data);
    end else begin
      match = (user_rd == byte_data);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/credential_entry_and_check.sv
// An accepted item waits in the input register until the result register is free or drained.
// Throughput: one item per cycle unless result_ready stalls it; an input register and a result register
// hold the two sides apart, and all the editing and compare logic sits between them.
// Reset (rst, synchronous, active high): phase returns to username enrollment,
// lengths and match bits clear, tries refill to 3, registers return to 3/5/6.
// Stored credential bytes keep whatever they held and are only read once written.
`default_nettype none

module credential_entry_and_check #(
  parameter int MAX_LEN = cec_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire cec_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output cec_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [4:0]       cfg_data
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;

  // Configuration registers.
  logic [3:0] max_tries;
  logic [3:0] lockout_seconds;
  logic [4:0] min_length;

  // Input stage and its advance condition.
  logic           s1_valid;
  cec_pkg::item_t s1_item;
  logic           advance;

  // Block state.
  cec_pkg::phase_t  phase, phase_next;
  logic [LEN_W-1:0]   user_len, user_len_next;
  logic [LEN_W-1:0]   pass_len, pass_len_next;
  logic [LEN_W-1:0]   typed_len, typed_len_next;
  logic [MAX_LEN-1:0] typed_match, typed_match_next;
  logic               user_ok, user_ok_next;
  logic [3:0]         tries_count, tries_count_next;
  logic [3:0]         lockout_count, lockout_count_next;
  cec_pkg::event_t    ev;

  // Store interface.
  cec_pkg::store_ctl_t st_ctl;
  logic                st_wr_en;
  logic                st_use_pass;
  logic                st_match;
  logic [IDX_W-1:0]    st_idx;
  logic [IDX_W-1:0]    st_rd_idx;

  // Decoded character and length views.
  logic             is_enter;
  logic             is_back;
  logic             at_zero;
  logic             at_full;
  logic             enrolling;
  logic             len_ok;
  logic [LEN_W-1:0] ref_len;
  logic             below_ref;
  logic [3:0]       tries_dec;
  logic [3:0]       lockout_dec;

  // Short views for the checks at the end.
  logic in_lockout;
  logic in_signed_in;
  logic lock_start_out;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tries       <= cec_pkg::MAX_TRIES_RESET;
      lockout_seconds <= cec_pkg::LOCKOUT_SECONDS_RESET;
      min_length      <= cec_pkg::MIN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cec_pkg::CFG_MAX_TRIES:       max_tries       <= cfg_data[3:0];
        cec_pkg::CFG_LOCKOUT_SECONDS: lockout_seconds <= cfg_data[3:0];
        cec_pkg::CFG_MIN_LENGTH:      min_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result register is free or being drained.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Credential bytes: written while enrolling, compared while signing in.
  // The store fetches the byte for the length the block will hold after this edge.
  assign st_idx      = typed_len[IDX_W-1:0];
  assign st_rd_idx   = advance ? typed_len_next[IDX_W-1:0] : typed_len[IDX_W-1:0];
  assign st_use_pass = (phase == cec_pkg::PH_ENROLL_PASS) ||
                       (phase == cec_pkg::PH_ENTER_PASS);
  assign st_ctl      = '{wr_en: st_wr_en, use_pass: st_use_pass};

  cec_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk       (clk),
    .ctl       (st_ctl),
    .idx       (st_idx),
    .rd_idx    (st_rd_idx),
    .byte_data (s1_item.char_code),
    .match     (st_match)
  );

  // Full match: exact length and every typed position matched.
  function automatic logic entry_matches(input logic [LEN_W-1:0]   len,
                                         input logic [LEN_W-1:0]   stored_len,
                                         input logic [MAX_LEN-1:0] bits);
    logic all_set;
    all_set = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((LEN_W'(i) < len) && !bits[i]) begin
        all_set = 1'b0;
      end
    end
    return (len == stored_len) && all_set;
  endfunction

  assign is_enter  = (s1_item.char_code == cec_pkg::CHAR_ENTER_CR) ||
                     (s1_item.char_code == cec_pkg::CHAR_ENTER_SI);
  assign is_back   = (s1_item.char_code == cec_pkg::CHAR_BACKSPACE);
  assign at_zero   = (typed_len == '0);
  assign at_full   = (typed_len == LEN_W'(MAX_LEN));
  assign enrolling = (phase == cec_pkg::PH_ENROLL_USER) ||
                     (phase == cec_pkg::PH_ENROLL_PASS);
  assign len_ok    = (CMP_W'(typed_len) >= CMP_W'(min_length));
  assign ref_len   = (phase == cec_pkg::PH_ENTER_USER) ? user_len : pass_len;
  assign below_ref = (typed_len < ref_len);
  assign tries_dec   = (tries_count != '0) ? tries_count - 4'd1 : tries_count;
  assign lockout_dec = (lockout_count != '0) ? lockout_count - 4'd1 : lockout_count;

  always_comb begin
    phase_next         = phase;
    user_len_next      = user_len;
    pass_len_next      = pass_len;
    typed_len_next     = typed_len;
    typed_match_next   = typed_match;
    user_ok_next       = user_ok;
    tries_count_next   = tries_count;
    lockout_count_next = lockout_count;
    ev                 = cec_pkg::EV_NONE;
    st_wr_en           = 1'b0;

    if (s1_item.kind == cec_pkg::KIND_TICK) begin
      // Ticks only count down a lockout; elsewhere they are dropped.
      if (phase == cec_pkg::PH_LOCKOUT) begin
        lockout_count_next = lockout_dec;
        if (lockout_dec == '0) begin
          ev               = cec_pkg::EV_LOCK_OVER;
          tries_count_next = max_tries;
          phase_next       = cec_pkg::PH_ENTER_USER;
          typed_len_next   = '0;
        end else begin
          ev = cec_pkg::EV_LOCK_TICK;
        end
      end
    end else begin
      unique case (phase)
        cec_pkg::PH_ENROLL_USER, cec_pkg::PH_ENROLL_PASS,
        cec_pkg::PH_ENTER_USER, cec_pkg::PH_ENTER_PASS: begin
          priority if (at_zero && (is_enter || is_back)) begin
            ev = cec_pkg::EV_NONE;
          end else if (is_enter) begin
            typed_len_next = '0;
            if (enrolling) begin
              // Enrollment ends only once the entry is long enough.
              if (!len_ok) begin
                ev = cec_pkg::EV_TOO_SHORT;
              end else if (phase == cec_pkg::PH_ENROLL_USER) begin
                user_len_next = typed_len;
                phase_next    = cec_pkg::PH_ENROLL_PASS;
                ev            = cec_pkg::EV_USER_ENROLL;
              end else begin
                pass_len_next = typed_len;
                phase_next    = cec_pkg::PH_ENTER_USER;
                ev            = cec_pkg::EV_PASS_ENROLL;
              end
            end else begin
              typed_match_next = '0;
              if (phase == cec_pkg::PH_ENTER_USER) begin
                user_ok_next = entry_matches(typed_len, user_len, typed_match);
                phase_next   = cec_pkg::PH_ENTER_PASS;
                ev           = cec_pkg::EV_USER_ENTERED;
              end else if (user_ok && entry_matches(typed_len, pass_len, typed_match)) begin
                tries_count_next = max_tries;
                phase_next       = cec_pkg::PH_SIGNED_IN;
                ev               = cec_pkg::EV_SIGNED_IN;
              end else begin
                // Failed sign-in: spend a try, lock out when none remain.
                tries_count_next = tries_dec;
                if (tries_dec != '0) begin
                  phase_next = cec_pkg::PH_ENTER_USER;
                  ev         = cec_pkg::EV_FAIL;
                end else begin
                  lockout_count_next = lockout_seconds;
                  phase_next         = cec_pkg::PH_LOCKOUT;
                  ev                 = cec_pkg::EV_LOCK_START;
                end
              end
            end
          end else if (is_back) begin
            typed_len_next = typed_len - LEN_W'(1);
            ev             = cec_pkg::EV_CHAR_TAKEN;
          end else if (!at_full) begin
            typed_len_next = typed_len + LEN_W'(1);
            ev             = cec_pkg::EV_CHAR_TAKEN;
            if (enrolling) begin
              st_wr_en = 1'b1;
            end else begin
              typed_match_next[st_idx] = below_ref && st_match;
            end
          end else begin
            // Drop printable bytes once the field is full.
            ev = cec_pkg::EV_NONE;
          end
        end
        cec_pkg::PH_LOCKOUT, cec_pkg::PH_SIGNED_IN: begin
          ev = cec_pkg::EV_NONE;
        end
        default: begin
          ev = cec_pkg::EV_NONE;
        end
      endcase
    end

    // Hold everything unless the item actually moves into the result register.
    if (!advance) begin
      st_wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cec_pkg::PH_ENROLL_USER;
      user_len      <= '0;
      pass_len      <= '0;
      typed_len     <= '0;
      typed_match   <= '0;
      user_ok       <= 1'b0;
      tries_count   <= cec_pkg::MAX_TRIES_RESET;
      lockout_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      user_len      <= user_len_next;
      pass_len      <= pass_len_next;
      typed_len     <= typed_len_next;
      typed_match   <= typed_match_next;
      user_ok       <= user_ok_next;
      tries_count   <= tries_count_next;
      lockout_count <= lockout_count_next;
    end
  end

  // Result register: load on advance, drop once the consumer takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.event_res    <= ev;
      result.tries_left   <= tries_count_next;
      result.seconds_left <= lockout_count_next;
      result.entry_length <= 5'(typed_len_next);
    end
  end

  assign in_lockout     = (phase == cec_pkg::PH_LOCKOUT);
  assign in_signed_in   = (phase == cec_pkg::PH_SIGNED_IN);
  assign lock_start_out = result_valid && (result.event_res == cec_pkg::EV_LOCK_START);

`include "credential_entry_and_check_macros.svh"

  `CEC_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, typed_len <= LEN_W'(MAX_LEN))
  `CEC_ASSERT_IMP(a_lockout_empty, clk, rst, in_lockout, typed_len == '0)
  `CEC_ASSERT_NEXT(a_signed_in_sticks, clk, rst, in_signed_in, in_signed_in)
  `CEC_ASSERT_IMP(a_lock_start_count, clk, rst, lock_start_out, result.seconds_left == lockout_seconds)

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for the credential entry and lockout block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS   = cec_pkg::MAX_LEN_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] text_t[$];

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block.
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  cec_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  cec_pkg::result_t result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [4:0]       cfg_data = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  credential_entry_and_check dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Lock state as the bench predicts it. Only the driver advances it, once per
  // accepted transfer; the stimulus process reads it to choose what to type.
  // --------------------------------------------------------------------------
  cec_pkg::phase_t      ph = cec_pkg::PH_ENROLL_USER;
  logic [7:0]           enrolled_user [0:MAX_CHARS-1];
  logic [7:0]           enrolled_pass [0:MAX_CHARS-1];
  logic [4:0]           user_count = '0;
  logic [4:0]           pass_count = '0;
  logic [4:0]           typed_count = '0;
  logic [MAX_CHARS-1:0] match_bits = '0;
  logic                 user_good = 1'b0;
  logic [3:0]           tries = cec_pkg::MAX_TRIES_RESET;
  logic [3:0]           lock_secs = '0;

  // Register copies, updated when a configuration transfer completes.
  logic [3:0] cfg_tries = cec_pkg::MAX_TRIES_RESET;
  logic [3:0] cfg_lock  = cec_pkg::LOCKOUT_SECONDS_RESET;
  logic [4:0] cfg_min   = cec_pkg::MIN_LENGTH_RESET;

  // Pending keystrokes and ticks, and the outcomes the block still owes us.
  cec_pkg::item_t   keystrokes [$];
  cec_pkg::result_t owed_outcomes [$];
  int               keys_queued = 0;
  int               keys_sent = 0;

  int      mismatches = 0;
  int      cycle_count = 0;
  int      checked = 0;
  int      seen [0:15];
  bit      steady = 1'b0;   // set to run a stretch with no idling on either side

  text_t   user_secret;
  text_t   pass_secret;
  text_t   draft;

  // Advance the predicted lock by one transfer and return what the block
  // should answer.
  function automatic cec_pkg::result_t expected_outcome(input cec_pkg::item_t it);
    cec_pkg::event_t      ev;
    logic                 enter_key, back_key, is_user, enrolling, whole;
    logic [4:0]           ref_len;
    logic [7:0]           ref_byte;
    logic [MAX_CHARS-1:0] want;
    cec_pkg::result_t     r;
    ev        = cec_pkg::EV_NONE;
    enter_key = (it.char_code == cec_pkg::CHAR_ENTER_CR) ||
                (it.char_code == cec_pkg::CHAR_ENTER_SI);
    back_key  = (it.char_code == cec_pkg::CHAR_BACKSPACE);
    is_user   = (ph == cec_pkg::PH_ENROLL_USER) || (ph == cec_pkg::PH_ENTER_USER);
    enrolling = (ph == cec_pkg::PH_ENROLL_USER) || (ph == cec_pkg::PH_ENROLL_PASS);
    ref_len   = is_user ? user_count : pass_count;

    if (it.kind == cec_pkg::KIND_TICK) begin
      // Ticks only matter while locked out; a count of zero ends it at once.
      if (ph == cec_pkg::PH_LOCKOUT) begin
        if (lock_secs != 0) lock_secs = lock_secs - 1'b1;
        if (lock_secs == 0) begin
          ev          = cec_pkg::EV_LOCK_OVER;
          tries       = cfg_tries;
          ph          = cec_pkg::PH_ENTER_USER;
          typed_count = '0;
        end else begin
          ev = cec_pkg::EV_LOCK_TICK;
        end
      end
    end else if (ph != cec_pkg::PH_LOCKOUT && ph != cec_pkg::PH_SIGNED_IN) begin
      if (typed_count == 0 && (enter_key || back_key)) begin
        ev = cec_pkg::EV_NONE;
      end else if (back_key) begin
        typed_count = typed_count - 1'b1;
        ev          = cec_pkg::EV_CHAR_TAKEN;
      end else if (!enter_key) begin
        // Drop printable bytes once the field is full.
        if (typed_count < MAX_CHARS) begin
          if (enrolling) begin
            if (is_user) enrolled_user[typed_count] = it.char_code;
            else enrolled_pass[typed_count] = it.char_code;
          end else if (typed_count < ref_len) begin
            ref_byte = is_user ? enrolled_user[typed_count] : enrolled_pass[typed_count];
            match_bits[typed_count] = (ref_byte == it.char_code);
          end else begin
            match_bits[typed_count] = 1'b0;
          end
          typed_count = typed_count + 1'b1;
          ev          = cec_pkg::EV_CHAR_TAKEN;
        end
      end else if (enrolling) begin
        if (typed_count >= cfg_min) begin
          if (is_user) begin
            user_count = typed_count;
            ph         = cec_pkg::PH_ENROLL_PASS;
            ev         = cec_pkg::EV_USER_ENROLL;
          end else begin
            pass_count = typed_count;
            ph         = cec_pkg::PH_ENTER_USER;
            ev         = cec_pkg::EV_PASS_ENROLL;
          end
        end else begin
          ev = cec_pkg::EV_TOO_SHORT;
        end
        typed_count = '0;
      end else begin
        // A match needs the stored length and a set bit at every typed position.
        want  = ~({MAX_CHARS{1'b1}} << typed_count);
        whole = (typed_count == ref_len) && ((match_bits & want) == want);
        if (is_user) begin
          user_good = whole;
          ph        = cec_pkg::PH_ENTER_PASS;
          ev        = cec_pkg::EV_USER_ENTERED;
        end else if (user_good && whole) begin
          tries = cfg_tries;
          ph    = cec_pkg::PH_SIGNED_IN;
          ev    = cec_pkg::EV_SIGNED_IN;
        end else begin
          if (tries != 0) tries = tries - 1'b1;
          if (tries != 0) begin
            ph = cec_pkg::PH_ENTER_USER;
            ev = cec_pkg::EV_FAIL;
          end else begin
            lock_secs = cfg_lock;
            ph        = cec_pkg::PH_LOCKOUT;
            ev        = cec_pkg::EV_LOCK_START;
          end
        end
        typed_count = '0;
        match_bits  = '0;
      end
    end

    r.event_res    = ev;
    r.tries_left   = tries;
    r.seconds_left = lock_secs;
    r.entry_length = typed_count;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one; never one while steady is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Any byte except Enter and backspace.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == cec_pkg::CHAR_ENTER_CR || b == cec_pkg::CHAR_ENTER_SI ||
           b == cec_pkg::CHAR_BACKSPACE);
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued keystrokes, advance the prediction on each transfer.
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (item_valid && item_ready) begin
        owed_outcomes.push_back(expected_outcome(item));
        keys_sent++;
      end
      // Hold the current item until it transfers; otherwise load the next.
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (keystrokes.size() != 0) begin
          item       <= keystrokes.pop_front();
          item_valid <= 1'b1;
          send_gap   <= pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result side at random and check each transfer against
  // the oldest owed outcome, field by field.
  // --------------------------------------------------------------------------
  int               stall = 0;
  cec_pkg::result_t owed;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall        <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (owed_outcomes.size() == 0) begin
          report_mismatch("result with nothing owed, event", result.event_res, 0);
        end else begin
          owed = owed_outcomes.pop_front();
          checked++;
          seen[owed.event_res]++;
          if (result.event_res !== owed.event_res)
            report_mismatch("event_res", result.event_res, owed.event_res);
          if (result.tries_left !== owed.tries_left)
            report_mismatch("tries_left", result.tries_left, owed.tries_left);
          if (result.seconds_left !== owed.seconds_left)
            report_mismatch("seconds_left", result.seconds_left, owed.seconds_left);
          if (result.entry_length !== owed.entry_length)
            report_mismatch("entry_length", result.entry_length, owed.entry_length);
        end
      end
      if (stall != 0) begin
        stall        <= stall - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall <= pick_gap();
      end
    end
  end

  // Watchdog: drop the run if it never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d outcomes owed", cycle_count,
               owed_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_key(input logic k, input logic [7:0] c);
    cec_pkg::item_t it;
    it.kind      = k;
    it.char_code = c;
    keystrokes.push_back(it);
    keys_queued++;
  endtask

  // Wait until every queued keystroke has transferred, so the predicted
  // state is current.
  task automatic sync_to_model();
    while (keys_sent != keys_queued) @(posedge clk);
  endtask

  // Wait until the block is idle: nothing queued, nothing owed.
  task automatic settle();
    while (keys_sent != keys_queued || owed_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cec_pkg::CFG_MAX_TRIES:       cfg_tries = val[3:0];
      cec_pkg::CFG_LOCKOUT_SECONDS: cfg_lock  = val[3:0];
      cec_pkg::CFG_MIN_LENGTH:      cfg_min   = val;
      default: ;
    endcase
  endtask

  // Fill draft with a secret, or with something guaranteed to differ from it.
  task automatic build_guess(input bit right, input bit of_user);
    int         pick, n, pos, k;
    logic [7:0] b;
    if (of_user) draft = user_secret;
    else draft = pass_secret;
    if (right) return;
    n    = draft.size();
    pick = $urandom_range(0, 3);
    if (pick == 1 && n == 1) pick = 2;
    if (pick == 2 && n == MAX_CHARS) pick = 1;
    case (pick)
      0: begin
        pos = $urandom_range(0, n - 1);
        do b = plain_byte(); while (b == draft[pos]);
        draft[pos] = b;
      end
      1: draft.delete(n - 1);
      2: draft.push_back(plain_byte());
      default: begin
        // Random text of another length, sometimes past the field limit.
        k = $urandom_range(1, MAX_CHARS + 2);
        if (k == n) k++;
        draft.delete();
        repeat (k) draft.push_back(plain_byte());
      end
    endcase
  endtask

  // Type the draft and end it with Enter; with noise, mix in corrected typos
  // and stray ticks.
  task automatic type_draft(input bit noise);
    foreach (draft[i]) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        push_key(cec_pkg::KIND_CHAR, plain_byte());
        push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_BACKSPACE);
      end
      if (noise && $urandom_range(0, 29) == 0) push_key(cec_pkg::KIND_TICK, 8'($urandom));
      push_key(cec_pkg::KIND_CHAR, draft[i]);
    end
    push_key(cec_pkg::KIND_CHAR,
             $urandom_range(0, 1) ? cec_pkg::CHAR_ENTER_CR : cec_pkg::CHAR_ENTER_SI);
  endtask

  // Feed enough ticks to end the current lockout, with ignored typing between.
  task automatic ride_out_lockout();
    int n;
    n = (lock_secs == 0) ? 1 : lock_secs;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) push_key(cec_pkg::KIND_CHAR, 8'($urandom));
      if ($urandom_range(0, 5) == 0) push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_ENTER_CR);
      push_key(cec_pkg::KIND_TICK, 8'($urandom));
    end
    if ($urandom_range(0, 4) == 0) push_key(cec_pkg::KIND_TICK, 8'($urandom));
  endtask

  // One sign-in attempt from the current predicted state. Never let both
  // halves be right here: signing in ends all further checking.
  task automatic run_attempt();
    bit user_right, pass_right;
    sync_to_model();
    if (ph == cec_pkg::PH_LOCKOUT) begin
      ride_out_lockout();
      return;
    end
    if (ph == cec_pkg::PH_ENTER_USER) begin
      user_right = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_BACKSPACE);
      build_guess(user_right, 1'b1);
      type_draft(1'b1);
    end else begin
      user_right = user_good;
    end
    pass_right = !user_right && ($urandom_range(0, 1) == 1);
    build_guess(pass_right, 1'b0);
    type_draft(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [3:0] tries_plan [0:5];
    logic [3:0] lock_plan [0:5];
    int         goal, ulen, plen;

    foreach (seen[i]) seen[i] = 0;
    foreach (enrolled_user[i]) begin
      enrolled_user[i] = '0;
      enrolled_pass[i] = '0;
    end
    tries_plan = '{4'd3, 4'd1, 4'd9, 4'd0, 4'($urandom_range(1, 9)), 4'($urandom_range(1, 9))};
    lock_plan  = '{4'd5, 4'd1, 4'd15, 4'd0, 4'($urandom_range(1, 15)),
                   4'($urandom_range(1, 15))};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Enrollment with a minimum no entry can reach: empty Enter and backspace,
    // ticks outside lockout, extreme bytes, one byte past the field limit.
    write_reg(cec_pkg::CFG_MIN_LENGTH, 5'd31);
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_ENTER_CR);
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_BACKSPACE);
    push_key(cec_pkg::KIND_TICK, 8'hA5);
    push_key(cec_pkg::KIND_TICK, 8'h5A);
    push_key(cec_pkg::KIND_CHAR, 8'h00);
    push_key(cec_pkg::KIND_CHAR, 8'hFF);
    repeat (MAX_CHARS - 1) push_key(cec_pkg::KIND_CHAR, plain_byte());
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_BACKSPACE);
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_ENTER_SI);

    // Pick the credentials; the username always carries a NUL.
    ulen = $urandom_range(6, 12);
    plen = $urandom_range(3, 10);
    repeat (ulen) user_secret.push_back(plain_byte());
    user_secret[$urandom_range(0, ulen - 1)] = 8'h00;
    repeat (plen) pass_secret.push_back(plain_byte());

    // Username one short of the minimum, then exactly at it.
    settle();
    write_reg(cec_pkg::CFG_MIN_LENGTH, 5'(ulen + 1));
    build_guess(1'b1, 1'b1);
    type_draft(1'b0);
    settle();
    write_reg(cec_pkg::CFG_MIN_LENGTH, 5'(ulen));
    type_draft(1'b1);

    // Password rejected at a minimum of 20, accepted at a minimum of 1.
    settle();
    write_reg(cec_pkg::CFG_MIN_LENGTH, 5'd20);
    build_guess(1'b1, 1'b0);
    type_draft(1'b0);
    settle();
    write_reg(cec_pkg::CFG_MIN_LENGTH, 5'd1);
    type_draft(1'b1);

    // Sign-in attempts under several retry and lockout settings, including
    // zero tries and a zero-length lockout.
    for (int p = 0; p < 6; p++) begin
      settle();
      steady = (p == 2);
      if (p > 0) begin
        write_reg(cec_pkg::CFG_MAX_TRIES, {1'b0, tries_plan[p]});
        write_reg(cec_pkg::CFG_LOCKOUT_SECONDS, {1'b0, lock_plan[p]});
      end
      goal = keys_queued + 115;
      while (keys_queued < goal) run_attempt();
    end

    // Get back to a clean username prompt, then sign in for real.
    settle();
    steady = 1'b0;
    write_reg(cec_pkg::CFG_MAX_TRIES, 5'($urandom_range(1, 9)));
    sync_to_model();
    while (ph != cec_pkg::PH_ENTER_USER) begin
      if (ph == cec_pkg::PH_LOCKOUT) begin
        ride_out_lockout();
      end else begin
        build_guess(1'b0, 1'b0);
        type_draft(1'b0);
      end
      sync_to_model();
    end
    build_guess(1'b1, 1'b1);
    type_draft(1'b1);
    build_guess(1'b1, 1'b0);
    type_draft(1'b1);

    // Once signed in, every item is dropped.
    push_key(cec_pkg::KIND_CHAR, plain_byte());
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_BACKSPACE);
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_ENTER_CR);
    push_key(cec_pkg::KIND_TICK, 8'($urandom));
    push_key(cec_pkg::KIND_CHAR, cec_pkg::CHAR_ENTER_SI);
    settle();

    if (owed_outcomes.size() != 0)
      report_mismatch("outcomes never returned", 0, owed_outcomes.size());

    $display("Checked %0d outcomes: %0d too-short entries, %0d failed sign-ins,",
             checked, seen[cec_pkg::EV_TOO_SHORT], seen[cec_pkg::EV_FAIL]);
    $display("%0d lockouts, %0d lockout ticks, %0d ignored items, %0d sign-in; %0d mismatches",
             seen[cec_pkg::EV_LOCK_START], seen[cec_pkg::EV_LOCK_TICK],
             seen[cec_pkg::EV_NONE], seen[cec_pkg::EV_SIGNED_IN], mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
